/* rtl/parallel_printer_handshake_top_defines.svh */
// Assertion macros used by the printer port engine.
`ifndef PARALLEL_PRINTER_HANDSHAKE_TOP_DEFINES_SVH
`define PARALLEL_PRINTER_HANDSHAKE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("printer port check failed");

// Next-cycle implication, checked outside reset.
`define PPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("printer port check failed");

`endif

/* rtl/pph_pkg.sv */
package pph_pkg;

	// Counter width default and configuration port geometry.
	localparam int COUNT_WIDTH_DEF = 21;
	localparam int CFG_INDEX_W     = 3;
	localparam int CFG_DATA_W      = 21;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_USE_ACK        = 3'd0,
		CFG_SETUP_TICKS    = 3'd1,
		CFG_STROBE_TICKS   = 3'd2,
		CFG_ACK_WAIT       = 3'd3,
		CFG_POLL_INTERVAL  = 3'd4,
		CFG_RETRY_LIMIT    = 3'd5,
		CFG_INIT_PULSE     = 3'd6,
		CFG_INIT_SETTLE    = 3'd7
	} cfg_idx_t;

	// Register reset values.
	localparam logic        USE_ACK_RST       = 1'b1;
	localparam logic [7:0]  SETUP_TICKS_RST   = 8'd1;
	localparam logic [7:0]  STROBE_TICKS_RST  = 8'd1;
	localparam logic [15:0] ACK_WAIT_RST      = 16'd1000;
	localparam logic [15:0] POLL_INTERVAL_RST = 16'd10000;
	localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd200;
	localparam logic [7:0]  INIT_PULSE_RST    = 8'd75;
	localparam logic [20:0] INIT_SETTLE_RST   = 21'd2000000;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SEND = 2'd1,
		OP_INIT = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		LS_READY     = 3'd0,
		LS_BUSY      = 3'd1,
		LS_OFFLINE   = 3'd2,
		LS_ERROR     = 3'd3,
		LS_NO_PAPER  = 3'd4
	} line_status_t;

	typedef enum logic [2:0] {
		OC_DONE         = 3'd0,
		OC_REF_ERROR    = 3'd1,
		OC_REF_OFFLINE  = 3'd2,
		OC_REF_PAPER    = 3'd3,
		OC_ACK_EXPIRED  = 3'd4,
		OC_BUSY_TIMEOUT = 3'd5,
		OC_INIT_DONE    = 3'd6
	} outcome_t;

	// Engine phases, one-hot.
	typedef enum logic [6:0] {
		PH_IDLE      = 7'b0000001,
		PH_BUSYWAIT  = 7'b0000010,
		PH_SETUP     = 7'b0000100,
		PH_STROBE    = 7'b0001000,
		PH_ACKWAIT   = 7'b0010000,
		PH_INITPULSE = 7'b0100000,
		PH_SETTLE    = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic        use_ack;
		logic [7:0]  setup_ticks;
		logic [7:0]  strobe_ticks;
		logic [15:0] ack_wait_limit;
		logic [15:0] busy_poll_interval;
		logic [7:0]  busy_retry_limit;
		logic [7:0]  init_pulse_ticks;
		logic [20:0] init_settle_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] data_byte;
		logic       ack_edge;
		logic       fault_edge;
		logic       fault_n;
		logic       busy_req;
		logic       selected;
		logic       paper_out;
	} item_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       strobe_n;
		logic       init_n;
		logic       idle;
		logic       accepted;
		logic [2:0] line_status;
		logic       finished;
		logic [2:0] outcome;
		logic       error_latched;
	} result_t;

	// Priority encode of the sampled printer lines.
	function automatic line_status_t encode_status(input item_t it);
		line_status_t st;
		if (it.paper_out)     st = LS_NO_PAPER;
		else if (!it.selected) st = LS_OFFLINE;
		else if (it.busy_req) st = LS_BUSY;
		else if (!it.fault_n) st = LS_ERROR;
		else                  st = LS_READY;
		return st;
	endfunction

endpackage

/* rtl/pph_cmd_if.sv */
// Command channel: one tick of sampled printer lines plus an optional command.
interface pph_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic       ack_edge;
	logic       fault_edge;
	logic       fault_n;
	logic       busy_req;
	logic       selected;
	logic       paper_out;

	modport source (
		output valid, opcode, data_byte, ack_edge, fault_edge, fault_n,
		busy_req, selected, paper_out,
		input ready
	);
	modport sink (
		input valid, opcode, data_byte, ack_edge, fault_edge, fault_n,
		busy_req, selected, paper_out,
		output ready
	);
endinterface

/* rtl/pph_res_if.sv */
// Result channel: port line levels and operation status for one tick.
interface pph_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       strobe_n;
	logic       init_n;
	logic       idle;
	logic       accepted;
	logic [2:0] line_status;
	logic       finished;
	logic [2:0] outcome;
	logic       error_latched;

	modport source (
		output valid, data_out, strobe_n, init_n, idle, accepted, line_status,
		finished, outcome, error_latched,
		input ready
	);
	modport sink (
		input valid, data_out, strobe_n, init_n, idle, accepted, line_status,
		finished, outcome, error_latched,
		output ready
	);
endinterface

/* rtl/pph_cfg.sv */
// Configuration register file with write-only access.
module pph_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pph_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [pph_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output pph_pkg::cfg_t                       cfg
);

	pph_pkg::cfg_t cfg_q;

	// Each write lands in one register, truncated to its width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_ack            <= pph_pkg::USE_ACK_RST;
			cfg_q.setup_ticks        <= pph_pkg::SETUP_TICKS_RST;
			cfg_q.strobe_ticks       <= pph_pkg::STROBE_TICKS_RST;
			cfg_q.ack_wait_limit     <= pph_pkg::ACK_WAIT_RST;
			cfg_q.busy_poll_interval <= pph_pkg::POLL_INTERVAL_RST;
			cfg_q.busy_retry_limit   <= pph_pkg::RETRY_LIMIT_RST;
			cfg_q.init_pulse_ticks   <= pph_pkg::INIT_PULSE_RST;
			cfg_q.init_settle_ticks  <= pph_pkg::INIT_SETTLE_RST;
		end else if (cfg_we) begin
			case (pph_pkg::cfg_idx_t'(cfg_index))
				pph_pkg::CFG_USE_ACK:       cfg_q.use_ack            <= cfg_wdata[0];
				pph_pkg::CFG_SETUP_TICKS:   cfg_q.setup_ticks        <= cfg_wdata[7:0];
				pph_pkg::CFG_STROBE_TICKS:  cfg_q.strobe_ticks       <= cfg_wdata[7:0];
				pph_pkg::CFG_ACK_WAIT:      cfg_q.ack_wait_limit     <= cfg_wdata[15:0];
				pph_pkg::CFG_POLL_INTERVAL: cfg_q.busy_poll_interval <= cfg_wdata[15:0];
				pph_pkg::CFG_RETRY_LIMIT:   cfg_q.busy_retry_limit   <= cfg_wdata[7:0];
				pph_pkg::CFG_INIT_PULSE:    cfg_q.init_pulse_ticks   <= cfg_wdata[7:0];
				pph_pkg::CFG_INIT_SETTLE:   cfg_q.init_settle_ticks  <= cfg_wdata[20:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/pph_engine.sv */
`include "parallel_printer_handshake_top_defines.svh"

// Port engine: one tick of state update per advance, result registered.
module pph_engine #(
	parameter int COUNT_WIDTH = pph_pkg::COUNT_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             adv,
	input  pph_pkg::item_t   item,
	input  pph_pkg::cfg_t    cfg,
	output pph_pkg::result_t result
);

	// Compare width covers both the counter and the widest limit.
	localparam int LW = ((COUNT_WIDTH > 21) ? COUNT_WIDTH : 21) + 1;

	pph_pkg::phase_t       phase_q, phase_d;
	logic [COUNT_WIDTH-1:0] tick_q, tick_d, tick_sat;
	logic [7:0]            poll_q, poll_d, poll_inc;
	logic [7:0]            held_q, held_d;
	logic                  ack_q, ack_d, fault_q, fault_d;
	logic [LW-1:0]         next_ext, cur_limit;
	logic                  done;
	pph_pkg::line_status_t status;
	logic                  accepted, finished;
	pph_pkg::outcome_t     outcome;
	pph_pkg::result_t      res_d, result_q;
	logic                  in_idle, strobe_next;

	// Saturating tick counter and end-of-phase compare.
	assign tick_sat = (tick_q == '1) ? tick_q : tick_q + 1'b1;
	assign next_ext = LW'(tick_q) + LW'(1);
	assign poll_inc = poll_q + 8'd1;

	always_comb begin
		case (phase_q)
			pph_pkg::PH_BUSYWAIT:  cur_limit = LW'(cfg.busy_poll_interval);
			pph_pkg::PH_SETUP:     cur_limit = LW'(cfg.setup_ticks);
			pph_pkg::PH_STROBE:    cur_limit = LW'(cfg.strobe_ticks);
			pph_pkg::PH_INITPULSE: cur_limit = LW'(cfg.init_pulse_ticks);
			pph_pkg::PH_SETTLE:    cur_limit = LW'(cfg.init_settle_ticks);
			default:               cur_limit = '0;
		endcase
	end

	assign done = (next_ext >= cur_limit);

	// Next state for one tick.
	always_comb begin
		status   = pph_pkg::encode_status(item);
		fault_d  = fault_q;
		if (status == pph_pkg::LS_READY) fault_d = 1'b0;
		if (item.fault_edge) fault_d = 1'b1;
		ack_d    = ack_q | item.ack_edge;
		phase_d  = phase_q;
		tick_d   = tick_q;
		poll_d   = poll_q;
		held_d   = held_q;
		accepted = 1'b0;
		finished = 1'b0;
		outcome  = pph_pkg::OC_DONE;

		case (phase_q)
			pph_pkg::PH_IDLE: begin
				if (item.opcode == pph_pkg::OP_SEND) begin
					accepted = 1'b1;
					if (status == pph_pkg::LS_NO_PAPER || status == pph_pkg::LS_OFFLINE ||
					    status == pph_pkg::LS_ERROR || fault_d) begin
						finished = 1'b1;
						if (status == pph_pkg::LS_NO_PAPER)     outcome = pph_pkg::OC_REF_PAPER;
						else if (status == pph_pkg::LS_OFFLINE) outcome = pph_pkg::OC_REF_OFFLINE;
						else                                    outcome = pph_pkg::OC_REF_ERROR;
					end else begin
						held_d = item.data_byte;
						tick_d = '0;
						if (status == pph_pkg::LS_READY) begin
							ack_d   = 1'b0;
							phase_d = pph_pkg::PH_SETUP;
						end else begin
							poll_d  = '0;
							phase_d = pph_pkg::PH_BUSYWAIT;
						end
					end
				end else if (item.opcode == pph_pkg::OP_INIT) begin
					accepted = 1'b1;
					ack_d    = 1'b0;
					held_d   = '0;
					tick_d   = '0;
					phase_d  = pph_pkg::PH_INITPULSE;
				end
			end
			pph_pkg::PH_BUSYWAIT: begin
				if (done) begin
					tick_d = '0;
					poll_d = poll_inc;
					if (poll_inc >= cfg.busy_retry_limit || poll_inc == 8'd0) begin
						finished = 1'b1;
						outcome  = pph_pkg::OC_BUSY_TIMEOUT;
						phase_d  = pph_pkg::PH_IDLE;
					end else if (status == pph_pkg::LS_READY) begin
						ack_d   = 1'b0;
						phase_d = pph_pkg::PH_SETUP;
					end
				end else begin
					tick_d = tick_sat;
				end
			end
			pph_pkg::PH_SETUP: begin
				if (done) begin
					tick_d  = '0;
					phase_d = pph_pkg::PH_STROBE;
				end else begin
					tick_d = tick_sat;
				end
			end
			pph_pkg::PH_STROBE: begin
				if (done) begin
					tick_d = '0;
					if (cfg.use_ack) begin
						phase_d = pph_pkg::PH_ACKWAIT;
					end else begin
						finished = 1'b1;
						phase_d  = pph_pkg::PH_IDLE;
					end
				end else begin
					tick_d = tick_sat;
				end
			end
			pph_pkg::PH_ACKWAIT: begin
				if (ack_d) begin
					ack_d    = 1'b0;
					finished = 1'b1;
					tick_d   = '0;
					phase_d  = pph_pkg::PH_IDLE;
				end else if (LW'(tick_sat) > LW'(cfg.ack_wait_limit)) begin
					finished = 1'b1;
					outcome  = pph_pkg::OC_ACK_EXPIRED;
					tick_d   = '0;
					phase_d  = pph_pkg::PH_IDLE;
				end else begin
					tick_d = tick_sat;
				end
			end
			pph_pkg::PH_INITPULSE: begin
				if (done) begin
					tick_d  = '0;
					phase_d = pph_pkg::PH_SETTLE;
				end else begin
					tick_d = tick_sat;
				end
			end
			pph_pkg::PH_SETTLE: begin
				if (done) begin
					finished = 1'b1;
					outcome  = pph_pkg::OC_INIT_DONE;
					tick_d   = '0;
					phase_d  = pph_pkg::PH_IDLE;
				end else begin
					tick_d = tick_sat;
				end
			end
			default: begin
				tick_d  = '0;
				phase_d = pph_pkg::PH_IDLE;
			end
		endcase

		// Line levels reflect the state after this tick.
		res_d.data_out      = held_d;
		res_d.strobe_n      = (phase_d != pph_pkg::PH_STROBE);
		res_d.init_n        = (phase_d != pph_pkg::PH_INITPULSE);
		res_d.idle          = (phase_d == pph_pkg::PH_IDLE);
		res_d.accepted      = accepted;
		res_d.line_status   = status;
		res_d.finished      = finished;
		res_d.outcome       = outcome;
		res_d.error_latched = fault_d;
	end

	// State and result registers advance together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pph_pkg::PH_IDLE;
			tick_q   <= '0;
			poll_q   <= '0;
			held_q   <= '0;
			ack_q    <= 1'b0;
			fault_q  <= 1'b0;
			result_q <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			poll_q   <= poll_d;
			held_q   <= held_d;
			ack_q    <= ack_d;
			fault_q  <= fault_d;
			result_q <= res_d;
		end
	end

	assign result = result_q;

	// Phase conditions used by the checks below.
	assign in_idle     = (phase_q == pph_pkg::PH_IDLE);
	assign strobe_next = phase_d inside {pph_pkg::PH_STROBE, pph_pkg::PH_ACKWAIT};

	`PPH_ASSERT_NEXT(a_idle_matches_state, clk, arst_n, adv, result_q.idle == in_idle)
	`PPH_ASSERT_IMPL(a_no_strobe_from_idle, clk, arst_n, adv && in_idle, !strobe_next)
	`PPH_ASSERT_NEXT(a_finish_goes_idle, clk, arst_n, adv && res_d.finished, in_idle)
	`PPH_ASSERT_NEXT(a_hold_without_adv, clk, arst_n, !adv, $stable(phase_q) && $stable(tick_q))

endmodule

/* rtl/parallel_printer_handshake_top.sv */
// Parallel printer port engine.
// cmd carries one tick of sampled printer lines (ack/fault edges, fault_n, busy_req,
// selected, paper_out) and an opcode: tick only, send data_byte, or start init.
// res returns one transaction per cmd transaction: data_out, strobe_n, init_n, idle,
// accepted, line_status, finished, outcome and error_latched, as they stand after
// that tick.
// Configuration is a write-only port (cfg_we, cfg_index, cfg_wdata); write only
// while no tick is in flight.
// A cmd transaction is captured in the input register, processed by the engine into
// its result register and then offered on res.
// Throughput: one tick per cycle while res is not stalled.
// A stalled res holds its result; one more tick waits in the input register,
// then cmd.ready drops until res drains.
// Reset clears the engine to idle and the configuration to its defaults; the input data register is not reset.
module parallel_printer_handshake_top #(
	parameter int COUNT_WIDTH = pph_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pph_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pph_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	pph_cmd_if.sink                         cmd,
	pph_res_if.source                       res
);

	logic             valid_s1;
	pph_pkg::item_t   item_s1;
	logic             out_valid_q;
	logic             adv;
	pph_pkg::cfg_t    cfg;
	pph_pkg::result_t result;

	// The engine steps when a tick waits and the result slot is free or draining.
	assign adv       = valid_s1 && (!out_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.opcode     <= cmd.opcode;
			item_s1.data_byte  <= cmd.data_byte;
			item_s1.ack_edge   <= cmd.ack_edge;
			item_s1.fault_edge <= cmd.fault_edge;
			item_s1.fault_n    <= cmd.fault_n;
			item_s1.busy_req   <= cmd.busy_req;
			item_s1.selected   <= cmd.selected;
			item_s1.paper_out  <= cmd.paper_out;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	pph_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pph_engine #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Result channel.
	assign res.valid         = out_valid_q;
	assign res.data_out      = result.data_out;
	assign res.strobe_n      = result.strobe_n;
	assign res.init_n        = result.init_n;
	assign res.idle          = result.idle;
	assign res.accepted      = result.accepted;
	assign res.line_status   = result.line_status;
	assign res.finished      = result.finished;
	assign res.outcome       = result.outcome;
	assign res.error_latched = result.error_latched;

endmodule

/* bench/tb_parallel_printer_handshake_top.sv */
`timescale 1ns / 1ps

module tb_parallel_printer_handshake_top;

	localparam int          STALL_LIMIT = 2000;
	localparam int unsigned TICK_SAT    = (1 << pph_pkg::COUNT_WIDTH_DEF) - 1;
	localparam int          DW          = pph_pkg::CFG_DATA_W;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [pph_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [DW-1:0]                   cfg_wdata;

	pph_cmd_if cmd_ch();
	pph_res_if res_ch();

	parallel_printer_handshake_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	// Ticks waiting to be driven and port reports waiting to be seen.
	pph_pkg::item_t   pending_ticks[$];
	pph_pkg::result_t expected_reports[$];
	pph_pkg::item_t   drive_item;
	pph_pkg::item_t   taken_item;
	pph_pkg::result_t seen_report;
	pph_pkg::result_t want_report;

	int mismatches;
	int results_seen;
	int stall_cycles;
	int send_gap;
	int recv_gap;

	// Shadow of the port engine: register copy and engine state.
	pph_pkg::cfg_t    shadow;
	pph_pkg::phase_t  eng_phase = pph_pkg::PH_IDLE;
	int unsigned      eng_ticks = 0;
	logic [7:0]       eng_polls = '0;
	logic [7:0]       eng_byte  = '0;
	bit               eng_ack   = 0;
	bit               eng_fault = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The engine enters a phase; the tick count restarts, and the entering tick is not counted.
	function automatic void enter_phase(pph_pkg::phase_t p);
		eng_phase = p;
		eng_ticks = 0;
	endfunction

	// One more tick in the current phase; true once the phase has lasted limit ticks.
	function automatic bit tick_expired(int unsigned limit);
		if (eng_ticks + 1 >= limit)
			return 1'b1;
		if (eng_ticks < TICK_SAT)
			eng_ticks++;
		return 1'b0;
	endfunction

	// Advances the shadow engine by one tick and returns the port report for it.
	function automatic pph_pkg::result_t advance_engine(pph_pkg::item_t it);
		pph_pkg::result_t      r;
		pph_pkg::line_status_t st;
		bit                    took;
		bit                    done;
		pph_pkg::outcome_t     oc;
		took = 1'b0;
		done = 1'b0;
		oc = pph_pkg::OC_DONE;

		if (it.paper_out)
			st = pph_pkg::LS_NO_PAPER;
		else if (!it.selected)
			st = pph_pkg::LS_OFFLINE;
		else if (it.busy_req)
			st = pph_pkg::LS_BUSY;
		else if (!it.fault_n)
			st = pph_pkg::LS_ERROR;
		else
			st = pph_pkg::LS_READY;

		// A fault edge in the same tick wins over the clear by a ready status.
		if (st == pph_pkg::LS_READY)
			eng_fault = 1'b0;
		if (it.fault_edge)
			eng_fault = 1'b1;
		if (it.ack_edge)
			eng_ack = 1'b1;

		case (eng_phase)
			pph_pkg::PH_IDLE: begin
				if (it.opcode == pph_pkg::OP_SEND) begin
					took = 1'b1;
					if (st == pph_pkg::LS_NO_PAPER || st == pph_pkg::LS_OFFLINE ||
					    st == pph_pkg::LS_ERROR || eng_fault) begin
						done = 1'b1;
						if (st == pph_pkg::LS_NO_PAPER)
							oc = pph_pkg::OC_REF_PAPER;
						else if (st == pph_pkg::LS_OFFLINE)
							oc = pph_pkg::OC_REF_OFFLINE;
						else
							oc = pph_pkg::OC_REF_ERROR;
					end else begin
						eng_byte = it.data_byte;
						if (st == pph_pkg::LS_READY) begin
							eng_ack = 1'b0;
							enter_phase(pph_pkg::PH_SETUP);
						end else begin
							eng_polls = '0;
							enter_phase(pph_pkg::PH_BUSYWAIT);
						end
					end
				end else if (it.opcode == pph_pkg::OP_INIT) begin
					took = 1'b1;
					eng_ack = 1'b0;
					eng_byte = '0;
					enter_phase(pph_pkg::PH_INITPULSE);
				end
			end
			pph_pkg::PH_BUSYWAIT: begin
				if (tick_expired(32'(shadow.busy_poll_interval))) begin
					eng_ticks = 0;
					eng_polls = eng_polls + 8'd1;
					if (eng_polls >= shadow.busy_retry_limit || eng_polls == 8'd0) begin
						done = 1'b1;
						oc = pph_pkg::OC_BUSY_TIMEOUT;
						enter_phase(pph_pkg::PH_IDLE);
					end else if (st == pph_pkg::LS_READY) begin
						eng_ack = 1'b0;
						enter_phase(pph_pkg::PH_SETUP);
					end
				end
			end
			pph_pkg::PH_SETUP: begin
				if (tick_expired(32'(shadow.setup_ticks)))
					enter_phase(pph_pkg::PH_STROBE);
			end
			pph_pkg::PH_STROBE: begin
				if (tick_expired(32'(shadow.strobe_ticks))) begin
					if (shadow.use_ack) begin
						enter_phase(pph_pkg::PH_ACKWAIT);
					end else begin
						done = 1'b1;
						oc = pph_pkg::OC_DONE;
						enter_phase(pph_pkg::PH_IDLE);
					end
				end
			end
			pph_pkg::PH_ACKWAIT: begin
				if (eng_ack) begin
					eng_ack = 1'b0;
					done = 1'b1;
					oc = pph_pkg::OC_DONE;
					enter_phase(pph_pkg::PH_IDLE);
				end else begin
					if (eng_ticks < TICK_SAT)
						eng_ticks++;
					if (eng_ticks > shadow.ack_wait_limit) begin
						done = 1'b1;
						oc = pph_pkg::OC_ACK_EXPIRED;
						enter_phase(pph_pkg::PH_IDLE);
					end
				end
			end
			pph_pkg::PH_INITPULSE: begin
				if (tick_expired(32'(shadow.init_pulse_ticks)))
					enter_phase(pph_pkg::PH_SETTLE);
			end
			pph_pkg::PH_SETTLE: begin
				if (tick_expired(32'(shadow.init_settle_ticks))) begin
					done = 1'b1;
					oc = pph_pkg::OC_INIT_DONE;
					enter_phase(pph_pkg::PH_IDLE);
				end
			end
			default: begin
				enter_phase(pph_pkg::PH_IDLE);
			end
		endcase

		r.data_out      = eng_byte;
		r.strobe_n      = (eng_phase != pph_pkg::PH_STROBE);
		r.init_n        = (eng_phase != pph_pkg::PH_INITPULSE);
		r.idle          = (eng_phase == pph_pkg::PH_IDLE);
		r.accepted      = took;
		r.line_status   = st;
		r.finished      = done;
		r.outcome       = oc;
		r.error_latched = eng_fault;
		return r;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic log_mismatch(string what, int got, int want);
		mismatches++;
		$display("mismatch on report %0d: %s is %0d, expected %0d",
			results_seen, what, got, want);
	endtask

	// Sampled printer lines that produce the given status; edges are clear, other lines are random.
	function automatic pph_pkg::item_t lines_for(pph_pkg::line_status_t st);
		pph_pkg::item_t it;
		it.opcode     = pph_pkg::OP_TICK;
		it.data_byte  = 8'($urandom_range(0, 255));
		it.ack_edge   = 1'b0;
		it.fault_edge = 1'b0;
		it.fault_n    = 1'($urandom_range(0, 1));
		it.busy_req   = 1'($urandom_range(0, 1));
		it.selected   = 1'($urandom_range(0, 1));
		it.paper_out  = 1'b0;
		case (st)
			pph_pkg::LS_NO_PAPER: begin
				it.paper_out = 1'b1;
			end
			pph_pkg::LS_OFFLINE: begin
				it.selected = 1'b0;
			end
			pph_pkg::LS_BUSY: begin
				it.selected = 1'b1;
				it.busy_req = 1'b1;
			end
			pph_pkg::LS_ERROR: begin
				it.selected = 1'b1;
				it.busy_req = 1'b0;
				it.fault_n  = 1'b0;
			end
			default: begin
				it.selected = 1'b1;
				it.busy_req = 1'b0;
				it.fault_n  = 1'b1;
			end
		endcase
		return it;
	endfunction

	task automatic push_tick(logic [1:0] op, logic [7:0] data, pph_pkg::line_status_t st,
		bit ack, bit fedge);
		pph_pkg::item_t it;
		it = lines_for(st);
		it.opcode     = op;
		it.data_byte  = data;
		it.ack_edge   = ack;
		it.fault_edge = fedge;
		pending_ticks.push_back(it);
	endtask

	// One command followed by the ticks that carry it through, or a burst of noise.
	task automatic add_session(bit slow);
		pph_pkg::item_t        it;
		pph_pkg::line_status_t st;
		int                    kind;
		int                    pick;
		int                    span;
		int                    ack_at;
		int                    busy_for;
		kind = slow ? 0 : $urandom_range(0, 99);
		span = slow ? $urandom_range(520, 545) : $urandom_range(3, 28);
		busy_for = 0;
		if (kind < 60) begin
			st = pph_pkg::LS_READY;
			pick = $urandom_range(0, 99);
			if (!slow) begin
				if (pick < 15) begin
					st = pph_pkg::LS_BUSY;
					busy_for = $urandom_range(1, 12);
				end else if (pick < 19) begin
					st = pph_pkg::LS_NO_PAPER;
				end else if (pick < 23) begin
					st = pph_pkg::LS_OFFLINE;
				end else if (pick < 27) begin
					st = pph_pkg::LS_ERROR;
				end
			end
			it = lines_for(st);
			it.opcode = pph_pkg::OP_SEND;
			it.fault_edge = ($urandom_range(0, 19) == 0);
			it.ack_edge = ($urandom_range(0, 9) == 0);
			pending_ticks.push_back(it);
		end else if (kind < 75) begin
			it = lines_for(pph_pkg::LS_READY);
			it.opcode = pph_pkg::OP_INIT;
			pending_ticks.push_back(it);
		end else begin
			repeat ($urandom_range(1, 4)) begin
				it.opcode     = 2'($urandom_range(0, 3));
				it.data_byte  = 8'($urandom_range(0, 255));
				it.ack_edge   = 1'($urandom_range(0, 1));
				it.fault_edge = 1'($urandom_range(0, 1));
				it.fault_n    = 1'($urandom_range(0, 1));
				it.busy_req   = 1'($urandom_range(0, 1));
				it.selected   = 1'($urandom_range(0, 1));
				it.paper_out  = 1'($urandom_range(0, 1));
				pending_ticks.push_back(it);
			end
			return;
		end
		ack_at = ($urandom_range(0, 4) == 0) ? -1 : $urandom_range(0, span - 1);
		for (int k = 0; k < span; k++) begin
			if (k < busy_for)
				st = pph_pkg::LS_BUSY;
			else if ($urandom_range(0, 29) == 0)
				st = pph_pkg::line_status_t'($urandom_range(0, 4));
			else
				st = pph_pkg::LS_READY;
			it = lines_for(st);
			if ($urandom_range(0, 9) == 0)
				it.opcode = 2'($urandom_range(0, 3));
			it.ack_edge = (k == ack_at) || ($urandom_range(0, 39) == 0);
			it.fault_edge = ($urandom_range(0, 49) == 0);
			pending_ticks.push_back(it);
		end
	endtask

	function automatic pph_pkg::cfg_t small_settings();
		pph_pkg::cfg_t c;
		c.use_ack            = 1'($urandom_range(0, 1));
		c.setup_ticks        = 8'($urandom_range(1, 4));
		c.strobe_ticks       = 8'($urandom_range(1, 4));
		c.ack_wait_limit     = 16'($urandom_range(1, 12));
		c.busy_poll_interval = 16'($urandom_range(1, 4));
		c.busy_retry_limit   = 8'($urandom_range(1, 5));
		c.init_pulse_ticks   = 8'($urandom_range(1, 4));
		c.init_settle_ticks  = 21'($urandom_range(1, 12));
		return c;
	endfunction

	task automatic write_reg(pph_pkg::cfg_idx_t idx, logic [DW-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
	endtask

	// Writes all eight registers and updates the shadow copy.
	task automatic program_regs(pph_pkg::cfg_t c);
		write_reg(pph_pkg::CFG_USE_ACK, DW'(c.use_ack));
		write_reg(pph_pkg::CFG_SETUP_TICKS, DW'(c.setup_ticks));
		write_reg(pph_pkg::CFG_STROBE_TICKS, DW'(c.strobe_ticks));
		write_reg(pph_pkg::CFG_ACK_WAIT, DW'(c.ack_wait_limit));
		write_reg(pph_pkg::CFG_POLL_INTERVAL, DW'(c.busy_poll_interval));
		write_reg(pph_pkg::CFG_RETRY_LIMIT, DW'(c.busy_retry_limit));
		write_reg(pph_pkg::CFG_INIT_PULSE, DW'(c.init_pulse_ticks));
		write_reg(pph_pkg::CFG_INIT_SETTLE, DW'(c.init_settle_ticks));
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow = c;
	endtask

	// Waits until every tick is driven and every report has come back.
	task automatic drain();
		while (!(pending_ticks.size() == 0 && !cmd_ch.valid && expected_reports.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Tick driver and result-side ready, both with random gaps.
	always @(posedge clk) begin
		if (arst_n) begin
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_gap) begin
					drive_item = pending_ticks.pop_front();
					cmd_ch.valid      <= 1'b1;
					cmd_ch.opcode     <= drive_item.opcode;
					cmd_ch.data_byte  <= drive_item.data_byte;
					cmd_ch.ack_edge   <= drive_item.ack_edge;
					cmd_ch.fault_edge <= drive_item.fault_edge;
					cmd_ch.fault_n    <= drive_item.fault_n;
					cmd_ch.busy_req   <= drive_item.busy_req;
					cmd_ch.selected   <= drive_item.selected;
					cmd_ch.paper_out  <= drive_item.paper_out;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(0, 99) >= recv_gap);
		end
	end

	// Monitor: checks each report transaction and predicts each tick transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				seen_report.data_out      = res_ch.data_out;
				seen_report.strobe_n      = res_ch.strobe_n;
				seen_report.init_n        = res_ch.init_n;
				seen_report.idle          = res_ch.idle;
				seen_report.accepted      = res_ch.accepted;
				seen_report.line_status   = res_ch.line_status;
				seen_report.finished      = res_ch.finished;
				seen_report.outcome       = res_ch.outcome;
				seen_report.error_latched = res_ch.error_latched;
				if (expected_reports.size() == 0) begin
					log_mismatch("unexpected report, pending count", 0, 1);
				end else begin
					want_report = expected_reports.pop_front();
					if (seen_report.data_out !== want_report.data_out)
						log_mismatch("data_out", int'(seen_report.data_out),
							int'(want_report.data_out));
					if (seen_report.strobe_n !== want_report.strobe_n)
						log_mismatch("strobe_n", int'(seen_report.strobe_n),
							int'(want_report.strobe_n));
					if (seen_report.init_n !== want_report.init_n)
						log_mismatch("init_n", int'(seen_report.init_n),
							int'(want_report.init_n));
					if (seen_report.idle !== want_report.idle)
						log_mismatch("idle", int'(seen_report.idle), int'(want_report.idle));
					if (seen_report.accepted !== want_report.accepted)
						log_mismatch("accepted", int'(seen_report.accepted),
							int'(want_report.accepted));
					if (seen_report.line_status !== want_report.line_status)
						log_mismatch("line_status", int'(seen_report.line_status),
							int'(want_report.line_status));
					if (seen_report.finished !== want_report.finished)
						log_mismatch("finished", int'(seen_report.finished),
							int'(want_report.finished));
					if (seen_report.outcome !== want_report.outcome)
						log_mismatch("outcome", int'(seen_report.outcome),
							int'(want_report.outcome));
					if (seen_report.error_latched !== want_report.error_latched)
						log_mismatch("error_latched", int'(seen_report.error_latched),
							int'(want_report.error_latched));
				end
				results_seen++;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				taken_item.opcode     = cmd_ch.opcode;
				taken_item.data_byte  = cmd_ch.data_byte;
				taken_item.ack_edge   = cmd_ch.ack_edge;
				taken_item.fault_edge = cmd_ch.fault_edge;
				taken_item.fault_n    = cmd_ch.fault_n;
				taken_item.busy_req   = cmd_ch.busy_req;
				taken_item.selected   = cmd_ch.selected;
				taken_item.paper_out  = cmd_ch.paper_out;
				expected_reports.push_back(advance_engine(taken_item));
			end
		end
	end

	// Watchdog on cycles in which no transaction completes.
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Reset, configuration phases and stimulus.
	initial begin
		pph_pkg::cfg_t settings;
		int            target;
		bit            slow;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_wdata         = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.opcode     = pph_pkg::OP_TICK;
		cmd_ch.data_byte  = '0;
		cmd_ch.ack_edge   = 1'b0;
		cmd_ch.fault_edge = 1'b0;
		cmd_ch.fault_n    = 1'b1;
		cmd_ch.busy_req   = 1'b0;
		cmd_ch.selected   = 1'b1;
		cmd_ch.paper_out  = 1'b0;
		res_ch.ready      = 1'b0;
		mismatches        = 0;
		results_seen      = 0;
		stall_cycles      = 0;
		send_gap          = 31;
		recv_gap          = 68;
		shadow.use_ack            = pph_pkg::USE_ACK_RST;
		shadow.setup_ticks        = pph_pkg::SETUP_TICKS_RST;
		shadow.strobe_ticks       = pph_pkg::STROBE_TICKS_RST;
		shadow.ack_wait_limit     = pph_pkg::ACK_WAIT_RST;
		shadow.busy_poll_interval = pph_pkg::POLL_INTERVAL_RST;
		shadow.busy_retry_limit   = pph_pkg::RETRY_LIMIT_RST;
		shadow.init_pulse_ticks   = pph_pkg::INIT_PULSE_RST;
		shadow.init_settle_ticks  = pph_pkg::INIT_SETTLE_RST;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed ticks with short limits so that every outcome shows up.
		settings.use_ack            = 1'b1;
		settings.setup_ticks        = 8'd1;
		settings.strobe_ticks       = 8'd1;
		settings.ack_wait_limit     = 16'd2;
		settings.busy_poll_interval = 16'd1;
		settings.busy_retry_limit   = 8'd2;
		settings.init_pulse_ticks   = 8'd1;
		settings.init_settle_ticks  = 21'd2;
		program_regs(settings);
		push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 0, 0);
		// Refusals on paper end, offline and error status.
		push_tick(pph_pkg::OP_SEND, 8'hFF, pph_pkg::LS_NO_PAPER, 0, 0);
		push_tick(pph_pkg::OP_SEND, 8'h00, pph_pkg::LS_OFFLINE, 0, 0);
		push_tick(pph_pkg::OP_SEND, 8'h00, pph_pkg::LS_ERROR, 0, 0);
		// A fault edge on a ready tick latches; a busy send is then refused by the latch.
		push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 0, 1);
		push_tick(pph_pkg::OP_SEND, 8'h55, pph_pkg::LS_BUSY, 0, 0);
		// A stale acknowledge is dropped when the byte is accepted.
		push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 1, 0);
		push_tick(pph_pkg::OP_SEND, 8'hA5, pph_pkg::LS_READY, 0, 0);
		push_tick(pph_pkg::OP_SEND, 8'h11, pph_pkg::LS_READY, 0, 0);
		push_tick(2'd3, 8'h22, pph_pkg::LS_READY, 0, 0);
		push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 1, 0);
		// No acknowledge: timeout after the limit plus one waiting ticks.
		push_tick(pph_pkg::OP_SEND, 8'h3C, pph_pkg::LS_READY, 0, 0);
		repeat (5) push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 0, 0);
		// Printer stays busy until the retry limit runs out.
		push_tick(pph_pkg::OP_SEND, 8'h81, pph_pkg::LS_BUSY, 0, 0);
		push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_BUSY, 0, 0);
		push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_BUSY, 0, 0);
		// Init pulse, settle and completion.
		push_tick(pph_pkg::OP_INIT, 8'hC3, pph_pkg::LS_READY, 0, 0);
		repeat (3) push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 0, 0);
		drain();

		// Random phases over several register settings and both extremes.
		for (int p = 1; p <= 8; p++) begin
			if (p <= 2) begin
				send_gap = 31;
				recv_gap = 68;
			end else if (p <= 5) begin
				send_gap = 68;
				recv_gap = 31;
			end else begin
				send_gap = 0;
				recv_gap = 0;
			end
			slow = (p == 4);
			if (p == 2) begin
				settings.use_ack            = 1'b0;
				settings.setup_ticks        = 8'd1;
				settings.strobe_ticks       = 8'd1;
				settings.ack_wait_limit     = 16'd1;
				settings.busy_poll_interval = 16'd1;
				settings.busy_retry_limit   = 8'd1;
				settings.init_pulse_ticks   = 8'd1;
				settings.init_settle_ticks  = 21'd1;
			end else if (slow) begin
				settings.use_ack            = 1'b1;
				settings.setup_ticks        = 8'd255;
				settings.strobe_ticks       = 8'd255;
				settings.ack_wait_limit     = 16'd65535;
				settings.busy_poll_interval = 16'd65535;
				settings.busy_retry_limit   = 8'd255;
				settings.init_pulse_ticks   = 8'd255;
				settings.init_settle_ticks  = 21'd2097151;
			end else begin
				settings = small_settings();
			end
			program_regs(settings);
			target = slow ? 500 : 140;
			while (pending_ticks.size() < target)
				add_session(slow);
			// Ready ticks at the end let short operations finish before the next write.
			if (!slow)
				repeat (40) push_tick(pph_pkg::OP_TICK, 8'h00, pph_pkg::LS_READY, 0, 0);
			drain();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
